### rtl/tmbarb_pkg.sv
// Shared types, constants and helper functions for the two-master bus ownership arbiter.
// Used by every module in rtl/. Has no dependencies of its own.
`default_nettype none

package tmbarb_pkg;

   // Width of the signed force and give-up timers.
   localparam int TIMER_WIDTH = 25;

   localparam int CFG_WIDTH   = 24;
   localparam int SHORT_WIDTH = 16;
   localparam int LONG_WIDTH  = 15;
   localparam int DELAY_WIDTH = 16;
   localparam int CSR_IDX_W   = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_AFTER   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GIVE_UP_AFTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_DELAY   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_DELAY    = 2'd3;

   localparam logic [CFG_WIDTH-1:0]   FORCE_AFTER_RST   = 24'd125000;
   localparam logic [CFG_WIDTH-1:0]   GIVE_UP_AFTER_RST = 24'd250000;
   localparam logic [SHORT_WIDTH-1:0] SHORT_DELAY_RST   = 16'd50;
   localparam logic [LONG_WIDTH-1:0]  LONG_DELAY_RST    = 15'd1000;

   // Item function codes.
   localparam logic FUNC_POLL    = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // Control byte bits.
   localparam int BIT_MYBUS   = 0;
   localparam int BIT_NMYBUS  = 1;
   localparam int BIT_BUSON   = 2;
   localparam int BIT_NBUSON  = 3;
   localparam int BIT_BUSINIT = 4;
   localparam int BIT_NTESTON = 7;
   // Interrupt status bit: the other master requests the bus.
   localparam int BIT_NMYTEST = 7;

   localparam logic [7:0] MASK_NTESTON = 8'h80;
   localparam logic [7:0] MASK_BUSINIT = 8'h10;

   // 3-bit command used to take the bus, indexed by the low nibble of the control byte.
   localparam logic [2:0] TAKE_CMD [0:15] = '{
      3'd4, 3'd0, 3'd1, 3'd5, 3'd4, 3'd4, 3'd5, 3'd5,
      3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd4, 3'd5, 3'd1
   };

   localparam logic [TIMER_WIDTH-1:0] TMAX = {1'b0, {(TIMER_WIDTH-1){1'b1}}};
   localparam logic [TIMER_WIDTH-1:0] TMIN = {1'b1, {(TIMER_WIDTH-1){1'b0}}};
   localparam int CMP_W = TIMER_WIDTH + CFG_WIDTH;

   typedef enum logic [2:0] {
      OUT_PENDING   = 3'd0,
      OUT_ACQUIRED  = 3'd1,
      OUT_TIMEOUT   = 3'd2,
      OUT_READ_ERR  = 3'd3,
      OUT_RELEASED  = 3'd4
   } outcome_type;

   typedef struct packed {
      logic       func;
      logic [7:0] control_byte;
      logic [7:0] status_byte;
      logic       read_failed;
   } item_type;

   typedef struct packed {
      logic                   write_enable;
      logic [7:0]             write_value;
      logic [DELAY_WIDTH-1:0] delay_us;
      outcome_type            outcome;
   } result_type;

   // Decision logic to timer block.
   typedef struct packed {
      logic                   fire;
      logic                   poll;
      logic                   advance;
      logic [DELAY_WIDTH-1:0] delay;
   } tmr_cmd_type;

   // Timer block to decision logic.
   typedef struct packed {
      logic forced;
      logic expired;
   } tmr_stat_type;

   // Clamp a configured time to the largest positive timer value.
   function automatic logic [TIMER_WIDTH-1:0] tload(input logic [CFG_WIDTH-1:0] v);
      logic [TIMER_WIDTH-1:0] r;
      if (CMP_W'(v) > CMP_W'(TMAX)) begin
         r = TMAX;
      end else begin
         r = TIMER_WIDTH'(CMP_W'(v));
      end
      return r;
   endfunction

   // Subtract a delay, saturating at the most negative timer value.
   function automatic logic [TIMER_WIDTH-1:0] tsub(input logic [TIMER_WIDTH-1:0] t,
                                                  input logic [DELAY_WIDTH-1:0] d);
      logic [TIMER_WIDTH:0] diff;
      diff = {t[TIMER_WIDTH-1], t} - (TIMER_WIDTH+1)'(d);
      if (diff[TIMER_WIDTH] != diff[TIMER_WIDTH-1]) begin
         return TMIN;
      end
      return diff[TIMER_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/tmbarb_timers.sv
// Attempt state and the signed force and give-up timers, with load and saturating subtract.
// Depends on tmbarb_pkg.
`default_nettype none

module tmbarb_timers (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tmbarb_pkg::tmr_cmd_type             cmd,
   input  wire logic [tmbarb_pkg::CFG_WIDTH-1:0]    force_after,
   input  wire logic [tmbarb_pkg::CFG_WIDTH-1:0]    give_up_after,
   output tmbarb_pkg::tmr_stat_type                 stat,
   output logic                                     attempt_active
);

   localparam int TW = tmbarb_pkg::TIMER_WIDTH;

   logic          active_ff, active_in;
   logic [TW-1:0] force_ff, force_in;
   logic [TW-1:0] giveup_ff, giveup_in;
   logic [TW-1:0] force_eff, giveup_eff;
   logic [TW-1:0] force_sub, giveup_sub;

   // The first poll of an attempt sees freshly loaded timers.
   always_comb begin
      if (cmd.poll && !active_ff) begin
         force_eff  = tmbarb_pkg::tload(force_after);
         giveup_eff = tmbarb_pkg::tload(give_up_after);
      end else begin
         force_eff  = force_ff;
         giveup_eff = giveup_ff;
      end
      force_sub    = tmbarb_pkg::tsub(force_eff, cmd.delay);
      giveup_sub   = tmbarb_pkg::tsub(giveup_eff, cmd.delay);
      stat.forced  = force_eff[TW-1] || (force_eff == '0);
      stat.expired = giveup_sub[TW-1] || (giveup_sub == '0);
   end

   always_comb begin
      active_in = active_ff;
      force_in  = force_ff;
      giveup_in = giveup_ff;
      if (cmd.fire) begin
         if (!cmd.poll) begin
            active_in = 1'b0;
         end else if (cmd.advance) begin
            force_in  = force_sub;
            giveup_in = giveup_sub;
            active_in = !stat.expired;
         end else begin
            force_in  = force_eff;
            giveup_in = giveup_eff;
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         force_ff  <= '0;
         giveup_ff <= '0;
      end else begin
         active_ff <= active_in;
         force_ff  <= force_in;
         giveup_ff <= giveup_in;
      end
   end

   assign attempt_active = active_ff;

endmodule

`default_nettype wire

### rtl/tmbarb_decide.sv
// Decodes the bus-on and ownership pairs and picks the control write, delay and outcome.
// Depends on tmbarb_pkg; pairs with tmbarb_timers for the timer checks.
`default_nettype none

module tmbarb_decide (
   input  wire logic                                  fire,
   input  wire tmbarb_pkg::item_type                  item,
   input  wire logic [tmbarb_pkg::SHORT_WIDTH-1:0]    short_delay,
   input  wire logic [tmbarb_pkg::LONG_WIDTH-1:0]     long_delay,
   input  wire tmbarb_pkg::tmr_stat_type              stat,
   output tmbarb_pkg::tmr_cmd_type                    cmd,
   output tmbarb_pkg::result_type                     result
);

   logic       bus_off;
   logic       bus_mine;
   logic       done;
   logic       wen;
   logic [7:0] wval;
   logic [7:0] take;
   logic [tmbarb_pkg::DELAY_WIDTH-1:0] dly;
   logic [7:0] ctl;

   always_comb begin
      ctl      = item.control_byte;
      bus_off  = ctl[tmbarb_pkg::BIT_NBUSON] == ctl[tmbarb_pkg::BIT_BUSON];
      bus_mine = ctl[tmbarb_pkg::BIT_NMYBUS] == ctl[tmbarb_pkg::BIT_MYBUS];
      take     = {5'b0, tmbarb_pkg::TAKE_CMD[ctl[3:0]]};
      wen      = 1'b0;
      wval     = '0;
      dly      = '0;
      done     = 1'b0;

      if (item.func == tmbarb_pkg::FUNC_POLL && !item.read_failed) begin
         if (bus_off) begin
            if (!item.status_byte[tmbarb_pkg::BIT_NMYTEST] || stat.forced) begin
               wen  = 1'b1;
               wval = take | tmbarb_pkg::MASK_NTESTON;
               dly  = short_delay;
            end else begin
               dly  = {long_delay, 1'b0};
            end
         end else if (bus_mine) begin
            if (ctl[tmbarb_pkg::BIT_NTESTON] || ctl[tmbarb_pkg::BIT_BUSINIT]) begin
               wen  = 1'b1;
               wval = ctl & ~(tmbarb_pkg::MASK_NTESTON | tmbarb_pkg::MASK_BUSINIT);
            end
            done = 1'b1;
         end else begin
            // The other master holds an active bus.
            dly = {1'b0, long_delay};
            if (stat.forced) begin
               wen  = 1'b1;
               wval = take | tmbarb_pkg::MASK_BUSINIT | tmbarb_pkg::MASK_NTESTON;
            end else if (!ctl[tmbarb_pkg::BIT_NTESTON]) begin
               wen  = 1'b1;
               wval = ctl | tmbarb_pkg::MASK_NTESTON;
            end
         end
      end else if (item.func == tmbarb_pkg::FUNC_RELEASE) begin
         if (!item.read_failed && !bus_off && bus_mine) begin
            wen  = 1'b1;
            wval = {5'b0, ctl[tmbarb_pkg::BIT_NBUSON], 2'b0};
         end
      end
   end

   always_comb begin
      cmd.fire    = fire;
      cmd.poll    = item.func == tmbarb_pkg::FUNC_POLL;
      cmd.advance = cmd.poll && !item.read_failed && !done;
      cmd.delay   = dly;

      result.write_enable = wen;
      result.write_value  = wval;
      result.delay_us     = '0;
      if (item.func == tmbarb_pkg::FUNC_RELEASE) begin
         result.outcome = tmbarb_pkg::OUT_RELEASED;
      end else if (item.read_failed) begin
         result.outcome = tmbarb_pkg::OUT_READ_ERR;
      end else if (done) begin
         result.outcome = tmbarb_pkg::OUT_ACQUIRED;
      end else if (stat.expired) begin
         result.outcome = tmbarb_pkg::OUT_TIMEOUT;
      end else begin
         result.outcome  = tmbarb_pkg::OUT_PENDING;
         result.delay_us = dly;
      end
   end

endmodule

`default_nettype wire

### rtl/two_master_bus_ownership_arbiter_unit.sv
// Top level of the two-master bus ownership arbiter: input register, configuration
// registers, result register. Depends on tmbarb_pkg, tmbarb_decide and tmbarb_timers.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_ready     func, control_byte, status_byte, read_failed
//   rsp_      out        rsp_valid / rsp_ready     write_enable, write_value, delay_us, outcome
//   csr_      in         csr_write_enable          csr_index, csr_wdata
//
// A beat is registered on entry and decided while it sits in the input register, unless the
// result register is held; its result is loaded into the output register at the end of the
// deciding cycle, and one beat per cycle flows while rsp_ready does not hold the result back.
// Throughput is set by the single decision pass, with the timers updated in the same cycle.
// Reset clears the attempt, the timers and both valid flags, and restores register defaults.
// When the result register is held by rsp_ready low, the input register stalls behind it.
`default_nettype none

module two_master_bus_ownership_arbiter_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_func,
   input  wire logic [7:0]                             req_control_byte,
   input  wire logic [7:0]                             req_status_byte,
   input  wire logic                                   req_read_failed,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_write_enable,
   output logic [7:0]                                  rsp_write_value,
   output logic [tmbarb_pkg::DELAY_WIDTH-1:0]          rsp_delay_us,
   output logic [2:0]                                  rsp_outcome,
   input  wire logic                                   csr_write_enable,
   input  wire logic [tmbarb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tmbarb_pkg::CFG_WIDTH-1:0]       csr_wdata
);

   logic [tmbarb_pkg::CFG_WIDTH-1:0]   force_after_ff;
   logic [tmbarb_pkg::CFG_WIDTH-1:0]   give_up_after_ff;
   logic [tmbarb_pkg::SHORT_WIDTH-1:0] short_delay_ff;
   logic [tmbarb_pkg::LONG_WIDTH-1:0]  long_delay_ff;

   logic                   in_vld_ff, in_vld_in;
   tmbarb_pkg::item_type   item_ff, item_in;
   logic                   out_vld_ff, out_vld_in;
   tmbarb_pkg::result_type res_ff, res_in;

   logic                     fire;
   logic                     accept;
   logic                     attempt_active;
   tmbarb_pkg::tmr_cmd_type  cmd;
   tmbarb_pkg::tmr_stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         force_after_ff   <= tmbarb_pkg::FORCE_AFTER_RST;
         give_up_after_ff <= tmbarb_pkg::GIVE_UP_AFTER_RST;
         short_delay_ff   <= tmbarb_pkg::SHORT_DELAY_RST;
         long_delay_ff    <= tmbarb_pkg::LONG_DELAY_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            tmbarb_pkg::CSR_FORCE_AFTER: begin
               force_after_ff <= csr_wdata;
            end
            tmbarb_pkg::CSR_GIVE_UP_AFTER: begin
               give_up_after_ff <= csr_wdata;
            end
            tmbarb_pkg::CSR_SHORT_DELAY: begin
               short_delay_ff <= csr_wdata[tmbarb_pkg::SHORT_WIDTH-1:0];
            end
            tmbarb_pkg::CSR_LONG_DELAY: begin
               long_delay_ff <= csr_wdata[tmbarb_pkg::LONG_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A beat is processed when the result register is empty or being drained.
   assign fire      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_vld_in            = accept ? 1'b1 : (fire ? 1'b0 : in_vld_ff);
      item_in              = item_ff;
      if (accept) begin
         item_in.func         = req_func;
         item_in.control_byte = req_control_byte;
         item_in.status_byte  = req_status_byte;
         item_in.read_failed  = req_read_failed;
      end
      out_vld_in = fire || (out_vld_ff && !rsp_ready);
   end

   tmbarb_decide u_decide (
      .fire        (fire),
      .item        (item_ff),
      .short_delay (short_delay_ff),
      .long_delay  (long_delay_ff),
      .stat        (stat),
      .cmd         (cmd),
      .result      (res_in)
   );

   tmbarb_timers u_timers (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .force_after    (force_after_ff),
      .give_up_after  (give_up_after_ff),
      .stat           (stat),
      .attempt_active (attempt_active)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (fire) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_write_enable = res_ff.write_enable;
   assign rsp_write_value  = res_ff.write_value;
   assign rsp_delay_us     = res_ff.delay_us;
   assign rsp_outcome      = res_ff.outcome;

   // A finished or failed attempt never reports a retry delay.
   a_delay_only_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != tmbarb_pkg::OUT_PENDING |-> rsp_delay_us == '0)
      else $error("nonzero delay on a non-pending result");

   // No write value without a write.
   a_value_needs_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_write_value == 8'h00)
      else $error("write value set without write enable");

   // A pending poll keeps the attempt running; any other outcome ends it.
   a_pending_keeps_attempt: assert property (@(posedge clock) disable iff (reset)
      fire && res_in.outcome == tmbarb_pkg::OUT_PENDING |=> attempt_active)
      else $error("pending poll did not keep the attempt active");

   a_other_ends_attempt: assert property (@(posedge clock) disable iff (reset)
      fire && res_in.outcome != tmbarb_pkg::OUT_PENDING |=> !attempt_active)
      else $error("attempt still active after a final outcome");

endmodule

`default_nettype wire
